// ===== sv/lspq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_pkg
// shared types, codes and defaults for the linear scan priority queue
// ----------------------------------------------------------------------------
package lspq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // fixed field widths
    localparam int ACT_W = 2;
    localparam int LEN_W = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_RESP
    } state_t;

    // read-return tracking between the sequencer and the best tracker
    typedef struct packed {
        logic rvalid;
        logic first;
    } scan_ctl_t;

    // status part of one result word
    typedef struct packed {
        logic             accepted;
        logic [LEN_W-1:0] length;
        logic             is_empty;
        logic             is_full;
    } status_t;

endpackage

// ===== sv/lspq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lspq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lspq_best.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_best
// running min/max tracker over the words returned by the scan reads
// ----------------------------------------------------------------------------
module lspq_best #(
    parameter int CAPACITY   = lspq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = lspq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        order_mode,
    input  lspq_pkg::scan_ctl_t         scan_ctl,
    input  logic [$clog2(CAPACITY)-1:0] rslot,
    input  logic [DATA_WIDTH-1:0]       rdata,
    output logic [DATA_WIDTH-1:0]       best_val,
    output logic [$clog2(CAPACITY)-1:0] best_slot,
    output logic [DATA_WIDTH-1:0]       head_val
);
    import lspq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic [DATA_WIDTH-1:0] best_val_reg;
    logic [ADDR_W-1:0]     best_slot_reg;
    logic [DATA_WIDTH-1:0] head_val_reg;
    logic                  better;

    // strict compare keeps the earliest entry on a tie
    assign better = order_mode ? (rdata > best_val_reg) : (rdata < best_val_reg);

    always_ff @(posedge aclk) begin
        if (scan_ctl.rvalid) begin
            if (scan_ctl.first) begin
                best_val_reg  <= rdata;
                best_slot_reg <= rslot;
                head_val_reg  <= rdata;
            end else if (better) begin
                best_val_reg  <= rdata;
                best_slot_reg <= rslot;
            end
        end
    end

    assign best_val  = best_val_reg;
    assign best_slot = best_slot_reg;
    assign head_val  = head_val_reg;

endmodule

// ===== sv/lspq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspq_ctrl
// operation sequencer: head/count state, ram access, result register
// ----------------------------------------------------------------------------
module lspq_ctrl #(
    parameter int CAPACITY   = lspq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = lspq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input word
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lspq_pkg::ACT_W-1:0]      s_action,
    input  logic [DATA_WIDTH-1:0]           s_data_in,
    // ram
    output logic                            ram_we,
    output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
    output logic [DATA_WIDTH-1:0]           ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
    // best tracker
    output lspq_pkg::scan_ctl_t             scan_ctl,
    output logic [$clog2(CAPACITY)-1:0]     rslot,
    input  logic [DATA_WIDTH-1:0]           best_val,
    input  logic [$clog2(CAPACITY)-1:0]     best_slot,
    input  logic [DATA_WIDTH-1:0]           head_val,
    // result word
    output logic                            m_valid,
    input  logic                            m_ready,
    output lspq_pkg::status_t               m_status,
    output logic [DATA_WIDTH-1:0]           m_data_out
);
    import lspq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [ADDR_W-1:0] LAST_SLT = ADDR_W'(CAPACITY - 1);

    state_t                state_reg,   state_next;
    logic [ACT_W-1:0]      act_reg,     act_next;
    logic [DATA_WIDTH-1:0] din_reg,     din_next;
    logic [ADDR_W-1:0]     head_reg,    head_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [ADDR_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]      rd_cnt_reg,  rd_cnt_next;
    scan_ctl_t             scan_reg,    scan_next;
    logic [ADDR_W-1:0]     rslot_reg,   rslot_next;
    logic                  acc_reg,     acc_next;
    logic [DATA_WIDTH-1:0] res_reg,     res_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg,  status_next;
    logic [DATA_WIDTH-1:0] dout_reg,    dout_next;

    logic                  out_free;
    logic                  issue;
    logic                  scan_done;
    logic [CNT_W:0]        tail_sum;
    logic [ADDR_W-1:0]     tail_slot;
    logic [ADDR_W-1:0]     head_inc;
    logic [ADDR_W-1:0]     rd_inc;

    assign out_free  = !m_valid_reg || m_ready;
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg < count_reg);
    assign scan_done = (rd_cnt_reg == count_reg) && !scan_reg.rvalid;

    // slot after the tail, head + count wrapped once
    assign tail_sum  = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_slot = (tail_sum >= (CNT_W+1)'(CAPACITY))
                     ? ADDR_W'(tail_sum - (CNT_W+1)'(CAPACITY))
                     : ADDR_W'(tail_sum);
    assign head_inc  = (head_reg == LAST_SLT) ? '0 : head_reg + 1'b1;
    assign rd_inc    = (rd_slot_reg == LAST_SLT) ? '0 : rd_slot_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (act_reg == ACT_DEQ && count_reg != '0) state_next = ST_SCAN;
                else state_next = ST_RESP;
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_SWAP_A;
            end
            ST_SWAP_A: state_next = ST_SWAP_B;
            ST_SWAP_B: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs to the handshake and the ram
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = tail_slot;
        ram_wdata = din_reg;
        ram_raddr = rd_slot_reg;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: begin
                ram_raddr = head_reg;
                ram_we    = (act_reg == ACT_ENQ) && (count_reg < CAP_CNT);
            end
            ST_SWAP_A: begin
                ram_we    = 1'b1;
                ram_waddr = best_slot;
                ram_wdata = head_val;
            end
            ST_SWAP_B: begin
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                ram_wdata = best_val;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        act_next     = act_reg;
        din_next     = din_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        rd_slot_next = rd_slot_reg;
        rd_cnt_next  = rd_cnt_reg;
        scan_next    = '{rvalid: 1'b0, first: 1'b0};
        rslot_next   = rslot_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        dout_next    = dout_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next = s_action;
                    din_next = s_data_in;
                end
            end
            ST_EXEC: begin
                acc_next = 1'b0;
                res_next = '0;
                case (act_reg)
                    ACT_ENQ: begin
                        if (count_reg < CAP_CNT) begin
                            count_next = count_reg + 1'b1;
                            acc_next   = 1'b1;
                        end
                    end
                    ACT_DEQ: begin
                        if (count_reg != '0) begin
                            // first read goes to the head slot
                            scan_next    = '{rvalid: 1'b1, first: 1'b1};
                            rslot_next   = head_reg;
                            rd_slot_next = head_inc;
                            rd_cnt_next  = CNT_W'(1);
                        end
                    end
                    ACT_CLR: begin
                        count_next = '0;
                        head_next  = '0;
                        acc_next   = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_next    = '{rvalid: 1'b1, first: 1'b0};
                    rslot_next   = rd_slot_reg;
                    rd_slot_next = rd_inc;
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
            end
            ST_SWAP_B: begin
                acc_next   = 1'b1;
                res_next   = best_val;
                count_next = count_reg - 1'b1;
                head_next  = (count_reg == CNT_W'(1)) ? '0 : head_inc;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    dout_next            = res_reg;
                    status_next.accepted = acc_reg;
                    status_next.length   = LEN_W'(count_reg);
                    status_next.is_empty = (count_reg == '0);
                    status_next.is_full  = (count_reg == CAP_CNT);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_cnt_reg  <= '0;
            scan_reg    <= '{rvalid: 1'b0, first: 1'b0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        din_reg     <= din_next;
        rd_slot_reg <= rd_slot_next;
        rslot_reg   <= rslot_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        dout_reg    <= dout_next;
    end

    assign scan_ctl   = scan_reg;
    assign rslot      = rslot_reg;
    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_data_out = dout_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_head_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> head_reg == '0)
        else $error("head not at slot zero while empty");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !ram_we)
        else $error("ram write during scan");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted word not executed");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rd_cnt_reg <= count_reg)
        else $error("scan read past live entries");

endmodule

// ===== sv/linear_scan_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_top
// bounded priority queue in an unsorted circular ram, dequeue by linear scan
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          word
//  s_        in         s_valid/s_ready    s_action, s_data_in
//  m_        out        m_valid/m_ready    m_accepted, m_data_out, m_length,
//                                          m_is_empty, m_is_full
//  cfg_      in         cfg_we             cfg_wdata (order_mode)
//
//  enqueue, clear and refused ops pass through ST_IDLE, ST_EXEC and ST_RESP;
//  the result word is registered in ST_RESP once the output register is free
//  dequeue passes through ST_IDLE, ST_EXEC, ST_SCAN, ST_SWAP_A, ST_SWAP_B and
//  ST_RESP: one ram read per live entry through the single read port, then
//  two writes for the swap into the head slot
//  one word is worked on at a time; the next word is taken once the result
//  sits in the output register, even if m_ready is low
//  synchronous active-low reset clears head, count and order_mode; the ram
//  needs no clearing since only live entries are ever read
// ----------------------------------------------------------------------------
module linear_scan_priority_queue_top #(
    parameter int CAPACITY   = lspq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = lspq_pkg::DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    // input word
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lspq_pkg::ACT_W-1:0] s_action,
    input  logic [DATA_WIDTH-1:0]      s_data_in,
    // result word
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [DATA_WIDTH-1:0]      m_data_out,
    output logic [lspq_pkg::LEN_W-1:0] m_length,
    output logic                       m_is_empty,
    output logic                       m_is_full
);
    import lspq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    // order register: 0 smallest first, 1 largest first
    logic order_mode_reg;

    // ram port signals
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // scan tracking
    scan_ctl_t             scan_ctl;
    logic [ADDR_W-1:0]     rslot;
    logic [DATA_WIDTH-1:0] best_val;
    logic [ADDR_W-1:0]     best_slot;
    logic [DATA_WIDTH-1:0] head_val;

    status_t               status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            order_mode_reg <= cfg_wdata;
        end
    end

    // entry store
    lspq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // min/max tracker fed by the read data of the scan
    lspq_best #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_best (
        .aclk       (aclk),
        .order_mode (order_mode_reg),
        .scan_ctl   (scan_ctl),
        .rslot      (rslot),
        .rdata      (ram_rdata),
        .best_val   (best_val),
        .best_slot  (best_slot),
        .head_val   (head_val)
    );

    // sequencer and output register
    lspq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_data_in  (s_data_in),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .scan_ctl   (scan_ctl),
        .rslot      (rslot),
        .best_val   (best_val),
        .best_slot  (best_slot),
        .head_val   (head_val),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (status),
        .m_data_out (m_data_out)
    );

    // unpack the status of the result word
    assign m_accepted = status.accepted;
    assign m_length   = status.length;
    assign m_is_empty = status.is_empty;
    assign m_is_full  = status.is_full;

endmodule
